@@ design/htm_pkg.sv @@
// Shared types, constants and lookup tables for the HDR tone mapper.
`timescale 1ns / 1ps

package htm_pkg;

    localparam int unsigned TABLE_BITS = 8;
    localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_MEASURE = 2'd1;
    localparam logic [1:0] KIND_MAP     = 2'd2;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_LEVEL = 2'd1;
    localparam logic [1:0] CFG_GAMMA = 2'd2;

    localparam logic [2:0] MODE_CLAMP      = 3'd0;
    localparam logic [2:0] MODE_NORMALIZE  = 3'd1;
    localparam logic [2:0] MODE_LEVEL_NORM = 3'd2;
    localparam logic [2:0] MODE_GAMMA      = 3'd3;
    localparam logic [2:0] MODE_CLAMP_GAMMA = 3'd4;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] red_in;
        logic [31:0] green_in;
        logic [31:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_MEASURE,
        OP_MAP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [2:0][31:0] chan;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] clamp_level;
        logic [15:0] gamma_exp;
    } t_cfg;

    typedef logic [TABLE_SIZE-1:0][16:0] t_log_tab;
    typedef logic [TABLE_SIZE-1:0][17:0] t_exp_tab;

    function automatic longint unsigned isqrt64(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Fractional log2 of 1 + i/2^T by repeated squaring in Q1.30.
    function automatic t_log_tab build_log();
        t_log_tab        tab;
        longint unsigned m;
        longint unsigned s;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            m = longint'(TABLE_SIZE + i) << (30 - TABLE_BITS);
            s = 0;
            for (int j = 0; j < 20; j++) begin
                m = (m * m + (64'd1 << 29)) >> 30;
                s = s << 1;
                if (m >= (64'd1 << 31)) begin
                    s = s | 64'd1;
                    m = m >> 1;
                end
            end
            tab[i] = 17'((s + 64'd8) >> 4);
        end
        return tab;
    endfunction

    // exp2 of i/2^T as a product of successive square roots of two.
    function automatic t_exp_tab build_exp();
        t_exp_tab        tab;
        longint unsigned root [TABLE_BITS+1];
        longint unsigned a;
        root[0] = 64'd1 << 31;
        for (int j = 1; j <= TABLE_BITS; j++) root[j] = isqrt64(root[j-1] << 30);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            a = 64'd1 << 30;
            for (int j = 0; j < TABLE_BITS; j++) begin
                if (((i >> (TABLE_BITS - 1 - j)) & 1) != 0) begin
                    a = (a * root[j+1] + (64'd1 << 29)) >> 30;
                end
            end
            tab[i] = 18'((a + (64'd1 << 13)) >> 14);
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log();
    localparam t_exp_tab EXP_TAB = build_exp();

endpackage

@@ design/htm_front.sv @@
// Front end: accepts input transactions, classifies them and forwards commands.
`timescale 1ns / 1ps

module htm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  htm_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output htm_pkg::t_cmd     o_cmd
);

    logic          r_valid;
    htm_pkg::t_cmd r_cmd;
    logic          w_accept;
    logic          w_keep;
    htm_pkg::t_op  w_op;

    assign o_in_stall = r_valid && i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign o_cmd      = r_cmd;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_keep = 1'b1;
        w_op   = htm_pkg::OP_MAP;
        unique case (i_in_data.kind)
            htm_pkg::KIND_RESTART: w_op = htm_pkg::OP_RESTART;
            htm_pkg::KIND_MEASURE: w_op = htm_pkg::OP_MEASURE;
            htm_pkg::KIND_MAP:     w_op = htm_pkg::OP_MAP;
            default:               w_keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_push) r_valid <= 1'b0;
            // An unused kind is dropped here and never reaches the back end.
            if (w_accept && w_keep) r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_cmd.op      <= w_op;
            r_cmd.chan[0] <= i_in_data.red_in;
            r_cmd.chan[1] <= i_in_data.green_in;
            r_cmd.chan[2] <= i_in_data.blue_in;
        end
    end

endmodule

@@ design/htm_queue.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module htm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  htm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output htm_pkg::t_cmd o_cmd
);

    localparam int unsigned CW = $clog2(htm_pkg::QUEUE_DEPTH + 1);

    htm_pkg::t_cmd                 r_mem [htm_pkg::QUEUE_DEPTH];
    logic [htm_pkg::QUEUE_AW-1:0]  r_wr;
    logic [htm_pkg::QUEUE_AW-1:0]  r_rd;
    logic [CW-1:0]                 r_count;

    assign o_full  = (r_count == CW'(htm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

@@ design/htm_back.sv @@
// Back end: frame peak, shared divider, table gamma and byte conversion.
`timescale 1ns / 1ps

module htm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htm_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  htm_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output htm_pkg::t_out_item o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_POST,
        S_LOG,
        S_MUL,
        S_EXP,
        S_BYTE,
        S_OUT
    } t_state;

    typedef htm_pkg::t_out_item t_out_item_l;

    t_state           r_state;
    logic [31:0]      r_peak;
    logic [2:0][31:0] r_x;
    logic [1:0]       r_chan;
    logic [31:0]      r_div;
    logic [31:0]      r_rem;
    logic [3:0]       r_cnt;
    logic [16:0]      r_q;
    logic [20:0]      r_n;
    logic [24:0]      r_t;
    logic [23:0]      r_v;
    logic [2:0][7:0]  r_res;
    logic             r_ovalid;
    t_out_item_l      r_out;

    logic [31:0] w_x;
    logic [31:0] w_lvl;
    logic [31:0] w_d;
    logic [32:0] w_rem2;
    logic [31:0] w_m1;
    logic [31:0] w_m2;
    logic [31:0] w_m3;
    logic [3:0]  w_p;
    logic [15:0] w_norm;
    logic [htm_pkg::TABLE_BITS-1:0] w_lidx;
    logic [20:0] w_n;
    logic [36:0] w_tfull;
    logic [9:0]  w_k;
    logic [16:0] w_f;
    logic [htm_pkg::TABLE_BITS-1:0] w_eidx;
    logic [23:0] w_pow;
    logic [31:0] w_prod;
    logic [7:0]  w_byte;

    assign o_pop       = i_q_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign w_x   = r_x[r_chan];
    assign w_lvl = {8'd0, i_cfg.clamp_level};
    assign w_d   = (i_cfg.mode == htm_pkg::MODE_LEVEL_NORM) ? w_lvl : r_peak;
    assign w_rem2 = {r_rem, 1'b0};

    assign w_m1 = (i_q_cmd.chan[0] > r_peak) ? i_q_cmd.chan[0] : r_peak;
    assign w_m2 = (i_q_cmd.chan[1] > w_m1) ? i_q_cmd.chan[1] : w_m1;
    assign w_m3 = (i_q_cmd.chan[2] > w_m2) ? i_q_cmd.chan[2] : w_m2;

    // Log stage: leading one of the quotient and the table entry below it.
    always_comb begin
        w_p = '0;
        for (int i = 0; i < 16; i++) begin
            if (r_q[i]) w_p = 4'(i);
        end
        w_norm = r_q[15:0] << (4'd15 - w_p);
        w_lidx = w_norm[14 -: htm_pkg::TABLE_BITS];
        w_n    = {(5'd16 - {1'b0, w_p}), 16'd0} - 21'(htm_pkg::LOG_TAB[w_lidx]);
    end

    assign w_tfull = 37'(i_cfg.gamma_exp) * 37'(r_n) + 37'd2048;

    // Exp stage: round the exponent up to a whole shift and a fraction.
    always_comb begin
        w_k    = {1'b0, r_t[24:16]} + ((r_t[15:0] != 16'd0) ? 10'd1 : 10'd0);
        w_f    = htm_pkg::ONE_Q16 - {1'b0, r_t[15:0]};
        w_eidx = w_f[15 -: htm_pkg::TABLE_BITS];
        if (r_t[15:0] == 16'd0) w_eidx = '0;
        if (w_k >= 10'd17) w_pow = '0;
        else w_pow = 24'(htm_pkg::EXP_TAB[w_eidx] >> w_k[4:0]);
    end

    assign w_prod = 32'(r_v) * 32'd255;
    assign w_byte = (w_prod[31:16] > 16'd255) ? 8'd255 : w_prod[23:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_peak   <= '0;
            r_ovalid <= 1'b0;
            r_chan   <= '0;
            r_cnt    <= '0;
        end else begin
            // In S_OUT the valid flag is handled by the state itself.
            if (r_ovalid && !i_out_stall && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_cmd.op)
                            htm_pkg::OP_RESTART: r_peak <= '0;
                            htm_pkg::OP_MEASURE: r_peak <= w_m3;
                            default: begin
                                r_x     <= i_q_cmd.chan;
                                r_chan  <= '0;
                                r_state <= S_SETUP;
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    r_div <= w_d;
                    r_rem <= w_x;
                    r_cnt <= '0;
                    r_q   <= '0;
                    case (i_cfg.mode)
                        htm_pkg::MODE_CLAMP: begin
                            r_v     <= (w_x > w_lvl) ? i_cfg.clamp_level : w_x[23:0];
                            r_state <= S_BYTE;
                        end
                        htm_pkg::MODE_NORMALIZE, htm_pkg::MODE_LEVEL_NORM,
                        htm_pkg::MODE_GAMMA, htm_pkg::MODE_CLAMP_GAMMA: begin
                            if (i_cfg.mode == htm_pkg::MODE_LEVEL_NORM && w_x > w_lvl) begin
                                r_v     <= 24'(htm_pkg::ONE_Q16);
                                r_state <= S_BYTE;
                            end else if (w_d == '0) begin
                                r_state <= S_POST;
                            end else if (w_x >= w_d) begin
                                r_q     <= htm_pkg::ONE_Q16;
                                r_state <= S_POST;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            r_v     <= '0;
                            r_state <= S_BYTE;
                        end
                    endcase
                end
                S_DIV: begin
                    // One quotient bit per cycle; the remainder stays below the divisor.
                    if (w_rem2 >= {1'b0, r_div}) begin
                        r_rem <= 32'(w_rem2 - {1'b0, r_div});
                        r_q   <= {r_q[15:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[31:0];
                        r_q   <= {r_q[15:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) r_state <= S_POST;
                end
                S_POST: begin
                    r_state <= S_BYTE;
                    if (i_cfg.mode == htm_pkg::MODE_NORMALIZE ||
                        i_cfg.mode == htm_pkg::MODE_LEVEL_NORM) begin
                        r_v <= 24'(r_q);
                    end else if (i_cfg.mode == htm_pkg::MODE_CLAMP_GAMMA &&
                                 24'(r_q) > i_cfg.clamp_level) begin
                        r_v <= 24'(htm_pkg::ONE_Q16);
                    end else if (r_q == '0) begin
                        r_v <= (i_cfg.gamma_exp == '0) ? 24'(htm_pkg::ONE_Q16) : '0;
                    end else if (r_q >= htm_pkg::ONE_Q16) begin
                        r_v <= 24'(htm_pkg::ONE_Q16);
                    end else begin
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    r_n     <= w_n;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_t     <= w_tfull[36:12];
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    r_v     <= w_pow;
                    r_state <= S_BYTE;
                end
                S_BYTE: begin
                    r_res[r_chan] <= w_byte;
                    if (r_chan == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_chan  <= r_chan + 1'b1;
                        r_state <= S_SETUP;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid        <= 1'b1;
                        r_out.red_out   <= r_res[0];
                        r_out.green_out <= r_res[1];
                        r_out.blue_out  <= r_res[2];
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ design/hdr_tone_mapper.sv @@
// HDR tone mapper top level: configuration registers and front/queue/back wiring.
//
// Input channel (i_in_valid, o_in_stall, i_in_data) takes restart, measure and
// map transactions; the frame is streamed once to measure its peak and once to map.
// Output channel (o_out_valid, i_out_stall, o_out_data) carries one transaction of
// 8-bit RGB per map transaction, in input order. Restart and measure give none.
// The configuration channel (i_cfg_valid, o_cfg_ready) is always ready; index 0 is
// the mode, 1 the clamp level, 2 the gamma exponent. Write it only while idle.
// Restart and measure pass the front register and the queue and are done in the back end's idle state.
// A map transaction takes its three channels in turn through one shared divider
// that yields one quotient bit per cycle, then a table log, a multiply and a table
// exp; clamp and the spare modes skip all of these and the normalize modes skip all but the divider.
// The back end takes the next command only once the last result is registered.
// A two-entry queue lets the front accept while the back works.
// Synchronous active-low reset clears the peak, the queue and the output valid
// and restores mode 1, level 1.0 and gamma 1.0.
// While the receiver stalls, the result is held; the back end then waits with the
// next result and the queue fills until o_in_stall rises.
`timescale 1ns / 1ps

module hdr_tone_mapper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  htm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output htm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    htm_pkg::t_cfg r_cfg;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_qvalid;
    htm_pkg::t_cmd w_fcmd;
    htm_pkg::t_cmd w_qcmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= htm_pkg::MODE_NORMALIZE;
            r_cfg.clamp_level <= 24'h010000;
            r_cfg.gamma_exp   <= 16'h1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                htm_pkg::CFG_MODE:  r_cfg.mode        <= i_cfg_data[2:0];
                htm_pkg::CFG_LEVEL: r_cfg.clamp_level <= i_cfg_data;
                htm_pkg::CFG_GAMMA: r_cfg.gamma_exp   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    htm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_fcmd)
    );

    htm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_cmd   (w_qcmd)
    );

    htm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_qvalid),
        .i_q_cmd     (w_qcmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid set right after reset");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("queue written while full");
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("queue read while empty");
    a_stall_holds_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_full)
        else $error("input stalled with queue room");
`endif

endmodule

@@ sim/tb_hdr_tone_mapper.sv @@
// Self-checking testbench for the HDR tone mapper: random frames under every mode.
`timescale 1ns / 1ps

module tb_hdr_tone_mapper;

    localparam logic [1:0] KIND_SPARE     = 2'd3;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
    localparam int         DRAIN_CYCLES   = 90;
    localparam int         CYCLE_LIMIT    = 900000;

    // Predicts the mapped pixels and holds them until the block delivers them.
    class tone_scoreboard;
        logic [2:0]  mode;
        logic [23:0] level;
        logic [15:0] gamma;
        logic [31:0] peak;
        logic [16:0] log2_frac [htm_pkg::TABLE_SIZE];
        logic [17:0] exp2_frac [htm_pkg::TABLE_SIZE];
        htm_pkg::t_out_item pending_pixels [$];
        int          errors;
        int          mapped;

        function new();
            longint unsigned root [htm_pkg::TABLE_BITS+1];
            longint unsigned m, s, a, trial;
            root[0] = 64'd1 << 31;
            for (int j = 1; j <= htm_pkg::TABLE_BITS; j++) begin
                s = root[j-1] << 30;
                a = 0;
                for (int b = 31; b >= 0; b--) begin
                    trial = a | (64'd1 << b);
                    if (trial * trial <= s) a = trial;
                end
                root[j] = a;
            end
            for (int i = 0; i < htm_pkg::TABLE_SIZE; i++) begin
                m = longint'(htm_pkg::TABLE_SIZE + i) << (30 - htm_pkg::TABLE_BITS);
                s = 0;
                for (int j = 0; j < 20; j++) begin
                    m = (m * m + (64'd1 << 29)) >> 30;
                    s = s << 1;
                    if (m >= (64'd1 << 31)) begin
                        s = s | 1;
                        m = m >> 1;
                    end
                end
                log2_frac[i] = 17'((s + 8) >> 4);
                a = 64'd1 << 30;
                for (int j = 0; j < htm_pkg::TABLE_BITS; j++)
                    if (((i >> (htm_pkg::TABLE_BITS - 1 - j)) & 1) != 0)
                        a = (a * root[j+1] + (64'd1 << 29)) >> 30;
                exp2_frac[i] = 18'((a + (64'd1 << 13)) >> 14);
            end
            errors = 0;
            mapped = 0;
            reset_state();
        endfunction

        function void reset_state();
            mode  = htm_pkg::MODE_NORMALIZE;
            level = 24'd65536;
            gamma = 16'd4096;
            peak  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                htm_pkg::CFG_MODE:  mode = data[2:0];
                htm_pkg::CFG_LEVEL: level = data;
                htm_pkg::CFG_GAMMA: gamma = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [16:0] ratio(logic [31:0] x, logic [31:0] d);
            logic [47:0] q;
            if (d == 0) return 0;
            q = {x, 16'd0} / d;
            return (q > 48'd65536) ? 17'd65536 : q[16:0];
        endfunction

        function logic [16:0] apply_gamma(logic [16:0] q);
            int unsigned     p, idx, k, f;
            logic [31:0]     n;
            longint unsigned t;
            if (q == 0) return (gamma == 0) ? 17'd65536 : 17'd0;
            if (q >= 17'd65536) return 17'd65536;
            p = 15;
            while (q[p] == 1'b0) p--;
            idx = ((int'(q) - (1 << p)) << htm_pkg::TABLE_BITS >> p) &
                  (htm_pkg::TABLE_SIZE - 1);
            n = ((16 - p) << 16) - log2_frac[idx];
            t = (longint'(gamma) * n + 2048) >> 12;
            if ((t & 64'hFFFF) == 0) begin
                k = 32'(t >> 16);
                f = 0;
            end else begin
                k = 32'((t >> 16) + 1);
                f = 32'(65536 - (t & 64'hFFFF));
            end
            if (k >= 17) return 0;
            return 17'(exp2_frac[(f >> (16 - htm_pkg::TABLE_BITS)) &
                                 (htm_pkg::TABLE_SIZE - 1)] >> k);
        endfunction

        function logic [7:0] to_byte(logic [31:0] v);
            longint unsigned b;
            b = (longint'(v) * 255) >> 16;
            return (b > 255) ? 8'd255 : b[7:0];
        endfunction

        function logic [7:0] map_channel(logic [31:0] x);
            logic [16:0] q;
            case (mode)
                htm_pkg::MODE_CLAMP:
                    return to_byte((x > level) ? 32'(level) : x);
                htm_pkg::MODE_NORMALIZE:
                    return to_byte(32'(ratio(x, peak)));
                htm_pkg::MODE_LEVEL_NORM:
                    return to_byte((x > level) ? 32'd65536 : 32'(ratio(x, 32'(level))));
                htm_pkg::MODE_GAMMA:
                    return to_byte(32'(apply_gamma(ratio(x, peak))));
                htm_pkg::MODE_CLAMP_GAMMA: begin
                    q = ratio(x, peak);
                    return to_byte((q > level) ? 32'd65536 : 32'(apply_gamma(q)));
                end
                default: return 0;
            endcase
        endfunction

        function void note_input(htm_pkg::t_in_item it);
            htm_pkg::t_out_item r;
            case (it.kind)
                htm_pkg::KIND_RESTART: peak = 0;
                htm_pkg::KIND_MEASURE: begin
                    if (it.red_in > peak) peak = it.red_in;
                    if (it.green_in > peak) peak = it.green_in;
                    if (it.blue_in > peak) peak = it.blue_in;
                end
                htm_pkg::KIND_MAP: begin
                    r.red_out   = map_channel(it.red_in);
                    r.green_out = map_channel(it.green_in);
                    r.blue_out  = map_channel(it.blue_in);
                    pending_pixels.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(htm_pkg::t_out_item got);
            htm_pkg::t_out_item want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %h", $time, got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            mapped++;
            if (got.red_out !== want.red_out) begin
                $display("%0t: red expected %0d actual %0d", $time, want.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== want.green_out) begin
                $display("%0t: green expected %0d actual %0d", $time,
                         want.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== want.blue_out) begin
                $display("%0t: blue expected %0d actual %0d", $time,
                         want.blue_out, got.blue_out);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    htm_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_stall;
    htm_pkg::t_out_item out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    tone_scoreboard sb;
    bit             quiet;
    int             cycles;
    int             items_sent;
    int             settings_run;

    hdr_tone_mapper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end

    // Receiver back-pressure in random bursts; none once the run goes quiet.
    initial begin
        out_stall = 0;
        forever begin
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 1)) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send_item(htm_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_valid <= 1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_pixel(logic [1:0] kind, logic [31:0] r, logic [31:0] g,
                              logic [31:0] b);
        htm_pkg::t_in_item it;
        it.kind     = kind;
        it.red_in   = r;
        it.green_in = g;
        it.blue_in  = b;
        send_item(it);
    endtask

    // Waits until every mapped pixel is back and the pipeline has had time to settle.
    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [2:0] m, logic [23:0] lvl, logic [15:0] g);
        drain();
        write_reg(htm_pkg::CFG_MODE, {21'd0, m});
        write_reg(htm_pkg::CFG_LEVEL, lvl);
        write_reg(htm_pkg::CFG_GAMMA, {8'd0, g});
        settings_run++;
    endtask

    function automatic logic [31:0] radiance();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 32'h0003_0000);
            default: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd0;
        endcase
    endfunction

    // One frame: restart, measure every pixel, then map them again amid stray and fresh items.
    task automatic stream_frame(int npix);
        logic [31:0] frame [$];
        int          pick;
        send_pixel(htm_pkg::KIND_RESTART, $urandom, $urandom, $urandom);
        for (int i = 0; i < 3 * npix; i++) frame.push_back(radiance());
        for (int i = 0; i < npix; i++)
            send_pixel(htm_pkg::KIND_MEASURE, frame[3*i], frame[3*i+1], frame[3*i+2]);
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                pick = $urandom_range(0, 3);
                send_pixel(pick[1:0], $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 7) == 0)
                send_pixel(htm_pkg::KIND_MAP, radiance(), radiance(), radiance());
            else
                send_pixel(htm_pkg::KIND_MAP, frame[3*i], frame[3*i+1], frame[3*i+2]);
        end
    endtask

    task automatic random_setting();
        logic [23:0] lvl;
        logic [15:0] g;
        case ($urandom_range(0, 3))
            0: lvl = 24'hFF_FFFF;
            1: lvl = 0;
            default: lvl = 24'($urandom_range(0, 24'h02_0000));
        endcase
        g = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'h4000));
        configure(3'($urandom_range(0, 4)), lvl, g);
    endtask

    initial begin
        sb = new();
        quiet = 0;
        cycles = 0;
        items_sent = 0;
        settings_run = 0;
        i_rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = htm_pkg::CFG_MODE;
        cfg_data = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset defaults, a map with no peak yet, extremes, the spare kind and the spare modes.
        send_pixel(htm_pkg::KIND_MAP, 32'h0001_0000, 32'hFFFF_FFFF, 32'd0);
        send_pixel(htm_pkg::KIND_MEASURE, 32'd0, 32'h0002_0000, 32'd1);
        send_pixel(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(htm_pkg::KIND_MAP, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000);
        send_pixel(htm_pkg::KIND_MEASURE, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_pixel(htm_pkg::KIND_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1);
        configure(htm_pkg::MODE_CLAMP, 24'hFF_FFFF, 16'hFFFF);
        send_pixel(htm_pkg::KIND_MAP, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0000_8000);
        configure(htm_pkg::MODE_LEVEL_NORM, 24'd0, 16'd0);
        send_pixel(htm_pkg::KIND_MAP, 32'd0, 32'd1, 32'hFFFF_FFFF);
        configure(htm_pkg::MODE_GAMMA, 24'd65536, 16'd0);
        send_pixel(htm_pkg::KIND_RESTART, 32'd0, 32'd0, 32'd0);
        send_pixel(htm_pkg::KIND_MEASURE, 32'h0001_0000, 32'd0, 32'd0);
        send_pixel(htm_pkg::KIND_MAP, 32'd0, 32'h0000_8000, 32'h0001_0000);
        configure(htm_pkg::MODE_GAMMA, 24'd65536, 16'hFFFF);
        send_pixel(htm_pkg::KIND_MAP, 32'd1, 32'h0000_FFFF, 32'h0003_0000);
        configure(htm_pkg::MODE_CLAMP_GAMMA, 24'd0, 16'd2048);
        send_pixel(htm_pkg::KIND_MAP, 32'd0, 32'h0000_4000, 32'h0001_0000);
        configure(MODE_SPARE_LO, 24'd65536, 16'd4096);
        send_pixel(htm_pkg::KIND_MAP, 32'h0000_4000, 32'hFFFF_FFFF, 32'd7);
        configure(MODE_SPARE_HI, 24'd65536, 16'd4096);
        send_pixel(htm_pkg::KIND_MAP, 32'h0000_4000, 32'hFFFF_FFFF, 32'd7);

        for (int s = 0; s < 12; s++) begin
            if (s < 5) configure(3'(s), 24'($urandom_range(0, 24'h02_0000)),
                                 16'($urandom_range(0, 16'h3000)));
            else random_setting();
            if (s == 10) quiet = 1;
            stream_frame($urandom_range(8, 16));
            stream_frame($urandom_range(8, 16));
        end

        drain();
        $display("Sent %0d transactions over %0d register settings; %0d pixels mapped.",
                 items_sent, settings_run, sb.mapped);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/htm_pkg.sv
design/htm_front.sv
design/htm_queue.sv
design/htm_back.sv
design/hdr_tone_mapper.sv
sim/tb_hdr_tone_mapper.sv
